/* sv/fspc_pkg.sv */
// Shared constants and types for the FFT shift pad/crop address generator.
`default_nettype none

package fspc_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = 11;  // register width, holds 0..MAX_DIM
  localparam int COORD_W   = 10;  // pixel coordinate width
  localparam int ADDR_W    = 20;
  localparam int CFG_IDX_W = 3;

  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IN_WIDTH   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IN_HEIGHT  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_OUT_WIDTH  = cfg_idx_t'(2);
  localparam cfg_idx_t REG_OUT_HEIGHT = cfg_idx_t'(3);

  localparam dim_t DIM_RESET = dim_t'(256);
  localparam dim_t DIM_MAX   = dim_t'(MAX_DIM);

  // Result of mapping one axis position onto the input
  typedef struct packed {
    logic valid;
    dim_t src;
  } axis_res_t;

endpackage

`default_nettype wire

/* sv/fspc_ifs.sv */
// Valid/ready channel interfaces for coordinates, results and configuration.
`default_nettype none

interface fspc_in_if
  import fspc_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t x_out;
  coord_t y_out;

  modport source (output valid, x_out, y_out, input ready);
  modport sink   (input valid, x_out, y_out, output ready);
endinterface

interface fspc_out_if
  import fspc_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   is_zero;
  coord_t src_x;
  coord_t src_y;
  addr_t  src_addr;
  logic   out_of_range;

  modport source (output valid, is_zero, src_x, src_y, src_addr, out_of_range,
                  input ready);
  modport sink   (input valid, is_zero, src_x, src_y, src_addr, out_of_range,
                  output ready);
endinterface

interface fspc_cfg_if
  import fspc_pkg::*;
();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  dim_t     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/fspc_axis.sv */
// One-axis swap-and-pad mapping from output position to input position.
`default_nettype none

module fspc_axis
  import fspc_pkg::*;
(
  input  dim_t      in_size,
  input  dim_t      out_size,
  input  coord_t    pos,
  output axis_res_t res
);

  dim_t half_in;
  dim_t first_end;
  dim_t p;
  dim_t s_low;
  dim_t s_crop;
  dim_t pad_start;

  always_comb begin
    half_in   = in_size >> 1;
    first_end = out_size - (out_size >> 1);   // out/2 rounded up
    p         = dim_t'(pos);
    s_low     = half_in + p;
    s_crop    = ((in_size - out_size) >> 1) + (p - first_end);
    pad_start = out_size - half_in;

    res.valid = 1'b0;
    res.src   = '0;
    if (p < first_end) begin
      res.valid = (s_low < in_size);
      res.src   = s_low;
    end else if (out_size <= in_size) begin
      res.valid = (s_crop < half_in);
      res.src   = s_crop;
    end else begin
      res.valid = (p >= pad_start);
      res.src   = p - pad_start;
    end
    if (!res.valid) begin
      res.src = '0;
    end
  end

endmodule

`default_nettype wire

/* sv/fft_shift_pad_crop_address.sv */
// Top level of the FFT shift pad/crop address generator.
`default_nettype none

// For each output pixel coordinate beat the block returns the input pixel that an
// FFT shift with zero padding or cropping places there, its linear address
// src_x + in_width*src_y, and flags for padding and for coordinates outside the
// output size. It has an input register and a result register with the mapping,
// multiply and add between them: one coordinate is accepted every cycle unless
// backpressure stalls both registers, and its result passes from the input register
// to the result register and is then valid on out_if. Sizes are written through
// the cfg channel (always ready, values above 1024 saturate) and must only change
// while no beat is in flight.
module fft_shift_pad_crop_address
  import fspc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  fspc_in_if.sink     in_if,
  fspc_out_if.source  out_if,
  fspc_cfg_if.sink    cfg_if
);

  dim_t in_width_r, in_height_r, out_width_r, out_height_r;
  dim_t cfg_val;

  // configuration
  assign cfg_if.ready = 1'b1;
  assign cfg_val = (cfg_if.data > DIM_MAX) ? DIM_MAX : cfg_if.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= DIM_RESET;
      in_height_r  <= DIM_RESET;
      out_width_r  <= DIM_RESET;
      out_height_r <= DIM_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_IN_WIDTH:   in_width_r   <= cfg_val;
        REG_IN_HEIGHT:  in_height_r  <= cfg_val;
        REG_OUT_WIDTH:  out_width_r  <= cfg_val;
        REG_OUT_HEIGHT: out_height_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_v_r, s2_v_r;
  logic s1_en, s2_en;

  assign s2_en = !s2_v_r || out_if.ready;
  assign s1_en = !s1_v_r || s2_en;
  assign in_if.ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_if.valid;
      if (s2_en) s2_v_r <= s1_v_r;
    end
  end

  // stage 1: input register
  coord_t x_r, y_r;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      x_r <= in_if.x_out;
      y_r <= in_if.y_out;
    end
  end

  // per-axis mapping
  axis_res_t res_x, res_y;

  fspc_axis u_axis_x (
    .in_size  (in_width_r),
    .out_size (out_width_r),
    .pos      (x_r),
    .res      (res_x)
  );

  fspc_axis u_axis_y (
    .in_size  (in_height_r),
    .out_size (out_height_r),
    .pos      (y_r),
    .res      (res_y)
  );

  logic   oor_nxt, zero_nxt;
  coord_t sx_nxt, sy_nxt;

  assign oor_nxt  = (dim_t'(x_r) >= out_width_r) || (dim_t'(y_r) >= out_height_r);
  assign zero_nxt = oor_nxt || !(res_x.valid && res_y.valid);
  assign sx_nxt   = zero_nxt ? '0 : res_x.src[COORD_W-1:0];
  assign sy_nxt   = zero_nxt ? '0 : res_y.src[COORD_W-1:0];

  // linear address
  logic [DIM_W+COORD_W-1:0] prod;
  addr_t addr_nxt;

  assign prod     = in_width_r * sy_nxt;
  assign addr_nxt = addr_t'(prod) + addr_t'(sx_nxt);

  // stage 2: result register
  logic   is_zero_r, out_of_range_r;
  coord_t src_x_r, src_y_r;
  addr_t  src_addr_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      is_zero_r      <= zero_nxt;
      out_of_range_r <= oor_nxt;
      src_x_r        <= sx_nxt;
      src_y_r        <= sy_nxt;
      src_addr_r     <= addr_nxt;
    end
  end

  assign out_if.valid        = s2_v_r;
  assign out_if.is_zero      = is_zero_r;
  assign out_if.src_x        = src_x_r;
  assign out_if.src_y        = src_y_r;
  assign out_if.src_addr     = src_addr_r;
  assign out_if.out_of_range = out_of_range_r;

endmodule

`default_nettype wire

/* tb/fspc_map_checker.sv */
// Checker for the FFT shift pad/crop address generator: predicts and compares every result beat.
`timescale 1ns / 100ps

module fspc_map_checker
  import fspc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fspc_in_if   coord_ch,
  fspc_out_if  map_ch,
  fspc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pend_count,
  output int   checked_count,
  output int   zero_count,
  output int   oor_count
);

  typedef struct packed {
    logic   is_zero;
    coord_t src_x;
    coord_t src_y;
    addr_t  src_addr;
    logic   out_of_range;
  } pix_src_t;

  dim_t     cur_in_w, cur_in_h, cur_out_w, cur_out_h;
  pix_src_t src_expect_q[$];

  // One axis of the swap-and-pad: where does output position pos come from?
  function automatic axis_res_t map_axis(input dim_t in_sz, input dim_t out_sz,
                                         input coord_t pos);
    int unsigned i = in_sz;
    int unsigned o = out_sz;
    int unsigned p = pos;
    int unsigned first_len = o / 2 + o % 2;
    int unsigned half_in = i / 2;
    int unsigned s;
    axis_res_t   r;
    r = '0;
    if (p < first_len) begin
      s = half_in + p;
      if (s < i) r = '{valid: 1'b1, src: dim_t'(s)};
    end else if (o <= i) begin
      // crop or equal size: second part taken from the middle of the lower half
      s = (i - o) / 2 + (p - first_len);
      if (s < half_in) r = '{valid: 1'b1, src: dim_t'(s)};
    end else begin
      // pad: lower half of the input sits at the far end of the output
      s = o - half_in;
      if (p >= s) r = '{valid: 1'b1, src: dim_t'(p - s)};
    end
    return r;
  endfunction

  function automatic pix_src_t predict_src(input coord_t x, input coord_t y);
    pix_src_t    res;
    axis_res_t   ax, ay;
    int unsigned lin;
    res = '0;
    res.out_of_range = (x >= cur_out_w) || (y >= cur_out_h);
    res.is_zero = 1'b1;
    if (!res.out_of_range) begin
      ax = map_axis(cur_in_w, cur_out_w, x);
      ay = map_axis(cur_in_h, cur_out_h, y);
      res.is_zero = !(ax.valid && ay.valid);
      if (!res.is_zero) begin
        res.src_x = coord_t'(ax.src);
        res.src_y = coord_t'(ay.src);
      end
    end
    lin = int'(res.src_x) + int'(cur_in_w) * int'(res.src_y);
    res.src_addr = addr_t'(lin);
    return res;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pix_src_t want;
    dim_t     wval;
    if (!rst_n) begin
      cur_in_w      = DIM_RESET;
      cur_in_h      = DIM_RESET;
      cur_out_w     = DIM_RESET;
      cur_out_h     = DIM_RESET;
      src_expect_q.delete();
      fail_count    = 0;
      pend_count    = 0;
      checked_count = 0;
      zero_count    = 0;
      oor_count     = 0;
    end else begin
      // result side first: a beat leaving now was never accepted at this edge
      if (map_ch.valid && map_ch.ready) begin
        if (src_expect_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: zero=%0b x=%0d y=%0d addr=%0d oor=%0b",
                   $time, map_ch.is_zero, map_ch.src_x, map_ch.src_y, map_ch.src_addr,
                   map_ch.out_of_range);
          fail_count++;
        end else begin
          want = src_expect_q.pop_front();
          checked_count++;
          if (want.is_zero) zero_count++;
          if (want.out_of_range) oor_count++;
          check_field("is_zero", want.is_zero, map_ch.is_zero);
          check_field("src_x", want.src_x, map_ch.src_x);
          check_field("src_y", want.src_y, map_ch.src_y);
          check_field("src_addr", want.src_addr, map_ch.src_addr);
          check_field("out_of_range", want.out_of_range, map_ch.out_of_range);
        end
      end
      if (coord_ch.valid && coord_ch.ready)
        src_expect_q.push_back(predict_src(coord_ch.x_out, coord_ch.y_out));
      if (cfg_ch.valid && cfg_ch.ready) begin
        wval = (cfg_ch.data > DIM_MAX) ? DIM_MAX : cfg_ch.data;
        case (cfg_ch.index)
          REG_IN_WIDTH:   cur_in_w = wval;
          REG_IN_HEIGHT:  cur_in_h = wval;
          REG_OUT_WIDTH:  cur_out_w = wval;
          REG_OUT_HEIGHT: cur_out_h = wval;
          default: ;
        endcase
      end
      pend_count = src_expect_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// Testbench top for the FFT shift pad/crop address generator: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module tb;
  import fspc_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_PHASE      = 4;
  localparam int PAUSE_PHASE     = 7;
  localparam int HOLD_CYCLES     = 64;
  localparam int HOLD_BEATS      = 40;

  typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned settings_run = 0;
  int unsigned sh_out_w = 256, sh_out_h = 256;
  int          fail_count, pend_count, checked_count, zero_count, oor_count;

  fspc_in_if  coord_ch ();
  fspc_out_if map_ch ();
  fspc_cfg_if cfg_ch ();

  fft_shift_pad_crop_address i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (coord_ch),
    .out_if (map_ch),
    .cfg_if (cfg_ch)
  );

  fspc_map_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .coord_ch      (coord_ch),
    .map_ch        (map_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pend_count    (pend_count),
    .checked_count (checked_count),
    .zero_count    (zero_count),
    .oor_count     (oor_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, pend_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall patterns of random length; a hold-off on request
  initial begin
    rx_mode_t    mode;
    int unsigned left;
    map_ch.ready = 1'b0;
    mode = RX_FLOW;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        map_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          RX_FLOW:   map_ch.ready <= 1'b1;
          RX_COIN:   map_ch.ready <= $urandom_range(0, 1);
          RX_SPARSE: map_ch.ready <= ($urandom_range(0, 7) != 0);
          default:   map_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // valid is left high so the next beat can follow without a gap.
  task automatic push_coord(input coord_t x, input coord_t y);
    coord_ch.valid <= 1'b1;
    coord_ch.x_out <= x;
    coord_ch.y_out <= y;
    do @(posedge clk); while (!coord_ch.ready);
    @(negedge clk);
  endtask

  task automatic go_quiet(input int unsigned n);
    coord_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    go_quiet(0);
    wait (pend_count == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input dim_t val, input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_sizes(input int unsigned iw, input int unsigned ih,
                           input int unsigned ow, input int unsigned oh);
    write_reg(REG_IN_WIDTH, dim_t'(iw), 1'b0);
    write_reg(REG_IN_HEIGHT, dim_t'(ih), 1'b0);
    write_reg(REG_OUT_WIDTH, dim_t'(ow), 1'b0);
    write_reg(REG_OUT_HEIGHT, dim_t'(oh), 1'b1);
    sh_out_w = (ow > MAX_DIM) ? MAX_DIM : ow;
    sh_out_h = (oh > MAX_DIM) ? MAX_DIM : oh;
    settings_run++;
  endtask

  function automatic int unsigned pick_dim();
    int unsigned r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return 1;
        2:       return MAX_DIM;
        default: return $urandom_range(MAX_DIM + 1, 2047);   // saturates
      endcase
    end
    if (r <= 2) return $urandom_range(1, MAX_DIM);
    return $urandom_range(1, 20);
  endfunction

  // Mostly inside the output, some around its edge, some anywhere
  function automatic coord_t pick_coord(input int unsigned lim);
    int unsigned r = $urandom_range(0, 7);
    int          v;
    if (r == 0 || lim == 0) return coord_t'($urandom_range(0, 1023));
    if (r == 1) begin
      v = int'(lim) + int'($urandom_range(0, 3)) - 2;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return coord_t'(v);
    end
    return coord_t'($urandom_range(0, lim - 1));
  endfunction

  initial begin
    int unsigned n, burst, gap;
    bit          steady, held, paused;
    coord_ch.valid = 1'b0;
    coord_ch.x_out = '0;
    coord_ch.y_out = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: 256 square, equal sizes
    push_coord(0, 0);
    push_coord(127, 128);
    push_coord(128, 127);
    push_coord(255, 255);
    push_coord(256, 3);
    push_coord(3, 256);
    push_coord(1023, 1023);
    drain();

    // pad: odd sizes across, even down; writes to unused indexes must not stick
    set_sizes(5, 4, 9, 6);
    write_reg(cfg_idx_t'(4), dim_t'($urandom_range(0, 2047)), 1'b0);
    write_reg(cfg_idx_t'(5), dim_t'($urandom_range(0, 2047)), 1'b0);
    write_reg(cfg_idx_t'(6), dim_t'($urandom_range(0, 2047)), 1'b0);
    write_reg(cfg_idx_t'(7), dim_t'($urandom_range(0, 2047)), 1'b1);
    push_coord(0, 0);
    push_coord(2, 3);
    push_coord(4, 5);
    push_coord(6, 2);
    push_coord(8, 0);
    drain();

    // crop, with the width written above the limit
    set_sizes(2047, 10, 1, 7);
    push_coord(0, 0);
    push_coord(0, 6);
    push_coord(1, 3);
    push_coord(0, 4);
    drain();

    // empty input width: all padding
    set_sizes(0, 3, 4, 2);
    push_coord(1, 1);
    push_coord(3, 0);
    drain();

    // empty output height: all out of range
    set_sizes(7, 1025, 3, 0);
    push_coord(0, 0);
    push_coord(2, 1023);
    drain();

    set_sizes(1, 1, 1, 1);
    push_coord(0, 0);
    push_coord(1, 0);

    held = 1'b0;
    paused = 1'b0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      set_sizes(pick_dim(), pick_dim(), pick_dim(), pick_dim());
      steady = (ph % 3 == 0);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if (ph == HOLD_PHASE && n >= 40 && !held) begin
          // receiver stops while beats keep coming, so the pipe fills and backs up
          hold_req = 1'b1;
          held = 1'b1;
          repeat (HOLD_BEATS) push_coord(pick_coord(sh_out_w), pick_coord(sh_out_h));
          n += HOLD_BEATS;
        end
        if (ph == PAUSE_PHASE && n >= 70 && !paused) begin
          drain();
          paused = 1'b1;
        end
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && n < ITEMS_PER_PHASE; b++) begin
          push_coord(pick_coord(sh_out_w), pick_coord(sh_out_h));
          n++;
        end
        if (!steady) begin
          gap = $urandom_range(0, 5);
          if (gap != 0) go_quiet(gap);
        end
      end
    end

    drain();
    $display("Run covered %0d size settings (pad, crop, empty, saturated) and %0d results,",
             settings_run, checked_count);
    $display("of which %0d padding and %0d outside the output, with stalls on both sides.",
             zero_count, oor_count);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
